FILE: design/rgb_to_hsv_convert_unit_defines.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter: assertion macros
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define RGBHSV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgbhsv: assertion failed");
// check a property on every clock edge, reset included
`define RGBHSV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rgbhsv: assertion failed");
`else
`define RGBHSV_ASSERT(label, clk, rst_n, prop)
`define RGBHSV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared constants and the control word that travels with each beat.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // default component width
  localparam int COMPONENT_BITS_DEF = 8;

  // hue is coded in 1/64 degree
  localparam int HUE_W             = 15;
  localparam int HUE_UNITS_SEXTANT = 3840;
  localparam int HUE_UNITS_TURN    = 23040;

  // control word carried alongside each beat in the pipeline
  typedef struct packed {
    logic valid;
    logic gray;   // max equals min: hue and saturation forced to zero
  } ctl_t;

endpackage

FILE: design/rgbhsv_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter: dual restoring divider pipeline
// Computes hue and saturation quotients side by side, one quotient bit per
// stage, with the control word and the value traveling alongside.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_convert_unit_defines.svh"

module rgbhsv_div_pipe #(
  parameter int COMP_W = rgbhsv_pkg::COMPONENT_BITS_DEF,
  parameter int STEPS  = rgbhsv_pkg::HUE_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rgbhsv_pkg::ctl_t        ctl_i,
  input  logic [COMP_W+STEPS-1:0] hue_num_i,
  input  logic [COMP_W-1:0]       hue_den_i,
  input  logic [COMP_W+STEPS-1:0] sat_num_i,
  input  logic [COMP_W-1:0]       sat_den_i,
  output rgbhsv_pkg::ctl_t        ctl_o,
  output logic [STEPS-1:0]        hue_q_o,
  output logic [STEPS-1:0]        sat_q_o,
  output logic [COMP_W-1:0]       val_o
);

  localparam int NW = COMP_W + STEPS;

  // per-stage registers: partial remainder, low numerator bits shifting
  // out while quotient bits shift in, and the divisor
  rgbhsv_pkg::ctl_t  ctl_r  [0:STEPS];
  logic [COMP_W-1:0] hrem_r [0:STEPS];
  logic [STEPS-1:0]  hlo_r  [0:STEPS];
  logic [COMP_W-1:0] hden_r [0:STEPS];
  logic [COMP_W-1:0] srem_r [0:STEPS];
  logic [STEPS-1:0]  slo_r  [0:STEPS];
  logic [COMP_W-1:0] sden_r [0:STEPS];

  // load the numerators: the top bits are already below the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
    end
    hrem_r[0] <= hue_num_i[NW-1:STEPS];
    hlo_r[0]  <= hue_num_i[STEPS-1:0];
    hden_r[0] <= hue_den_i;
    srem_r[0] <= sat_num_i[NW-1:STEPS];
    slo_r[0]  <= sat_num_i[STEPS-1:0];
    sden_r[0] <= sat_den_i;
  end

  // one quotient bit per stage for each divider
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [COMP_W:0]   hpart;
    logic              hbit;
    logic [COMP_W-1:0] hrem_nxt;
    logic [COMP_W:0]   spart;
    logic              sbit;
    logic [COMP_W-1:0] srem_nxt;

    assign hpart    = {hrem_r[k-1], hlo_r[k-1][STEPS-1]};
    assign hbit     = hpart >= {1'b0, hden_r[k-1]};
    assign hrem_nxt = hbit ? COMP_W'(hpart - {1'b0, hden_r[k-1]}) : hpart[COMP_W-1:0];

    assign spart    = {srem_r[k-1], slo_r[k-1][STEPS-1]};
    assign sbit     = spart >= {1'b0, sden_r[k-1]};
    assign srem_nxt = sbit ? COMP_W'(spart - {1'b0, sden_r[k-1]}) : spart[COMP_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_r[k-1];
      end
      hrem_r[k] <= hrem_nxt;
      hlo_r[k]  <= {hlo_r[k-1][STEPS-2:0], hbit};
      hden_r[k] <= hden_r[k-1];
      srem_r[k] <= srem_nxt;
      slo_r[k]  <= {slo_r[k-1][STEPS-2:0], sbit};
      sden_r[k] <= sden_r[k-1];
    end
  end

  // the saturation divisor is the value itself
  assign ctl_o   = ctl_r[STEPS];
  assign hue_q_o = hlo_r[STEPS];
  assign sat_q_o = slo_r[STEPS];
  assign val_o   = sden_r[STEPS];

  `RGBHSV_ASSERT(a_hue_rem_below_den, clk, rst_n, ctl_r[STEPS].valid && !ctl_r[STEPS].gray |-> hrem_r[STEPS] < hden_r[STEPS])
  `RGBHSV_ASSERT(a_sat_rem_below_den, clk, rst_n, ctl_r[STEPS].valid && !ctl_r[STEPS].gray |-> srem_r[STEPS] < sden_r[STEPS])
  `RGBHSV_ASSERT(a_valid_origin, clk, rst_n, ctl_o.valid |-> $past(ctl_i.valid, STEPS + 1))

endmodule

FILE: design/rgb_to_hsv_convert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Path: stage A, stage B, the divider pipeline (one quotient bit per stage,
//   DIV_STEPS = max(15, COMPONENT_BITS)), then the output register.
// Throughput: one pixel per cycle; busy stays low, nothing stalls.
// Reset: synchronous, active low; clears all valid bits, drops beats in flight.
// Results show for one cycle on out_valid; the receiver cannot hold them off.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_convert_unit_defines.svh"

module rgb_to_hsv_convert_unit #(
  parameter int COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COMPONENT_BITS-1:0]     in_red_in,
  input  logic [COMPONENT_BITS-1:0]     in_green_in,
  input  logic [COMPONENT_BITS-1:0]     in_blue_in,
  output logic                          out_valid,
  output logic [rgbhsv_pkg::HUE_W-1:0]  out_hue_out,
  output logic [COMPONENT_BITS-1:0]     out_sat_out,
  output logic [COMPONENT_BITS-1:0]     out_val_out
);

  localparam int W         = COMPONENT_BITS;
  localparam int TW        = W + 3;
  localparam int DIV_STEPS = (W > rgbhsv_pkg::HUE_W) ? W : rgbhsv_pkg::HUE_W;
  localparam int NW        = W + DIV_STEPS;
  localparam int LATENCY   = DIV_STEPS + 4;

  // which component holds the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // the pipeline never stalls
  assign busy = 1'b0;

  // ---------------- stage A: max, min, delta, signed difference ----------------
  logic         red_top;
  logic         green_top;
  logic [1:0]   sel_nxt;
  logic [W-1:0] mx_nxt;
  logic [W-1:0] mn_rg;
  logic [W-1:0] mn_nxt;
  logic [W:0]   diff_nxt;

  logic         valid_a_r;
  logic         gray_a_r;
  logic [1:0]   sel_a_r;
  logic [W-1:0] mx_a_r;
  logic [W-1:0] delta_a_r;
  logic [W:0]   diff_a_r;

  // pick the maximum, red winning ties, then green
  always_comb begin
    red_top   = (in_red_in >= in_green_in) && (in_red_in >= in_blue_in);
    green_top = !red_top && (in_green_in >= in_blue_in);
    if (red_top) begin
      sel_nxt = SEL_RED;
    end else if (green_top) begin
      sel_nxt = SEL_GREEN;
    end else begin
      sel_nxt = SEL_BLUE;
    end
    mn_rg  = (in_red_in < in_green_in) ? in_red_in : in_green_in;
    mn_nxt = (mn_rg < in_blue_in) ? mn_rg : in_blue_in;
    case (sel_nxt)
      SEL_RED: begin
        mx_nxt   = in_red_in;
        diff_nxt = {1'b0, in_green_in} - {1'b0, in_blue_in};
      end
      SEL_GREEN: begin
        mx_nxt   = in_green_in;
        diff_nxt = {1'b0, in_blue_in} - {1'b0, in_red_in};
      end
      default: begin
        mx_nxt   = in_blue_in;
        diff_nxt = {1'b0, in_red_in} - {1'b0, in_green_in};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= start && !busy;
    end
    gray_a_r  <= (mx_nxt == mn_nxt);
    sel_a_r   <= sel_nxt;
    mx_a_r    <= mx_nxt;
    delta_a_r <= mx_nxt - mn_nxt;
    diff_a_r  <= diff_nxt;
  end

  // ---------------- stage B: add the sextant offset ----------------
  // t = diff + k * delta, k in {0, 2, 4, 6}; always in [0, 6 * delta)
  logic [TW-1:0]    kd;
  logic [TW-1:0]    t_nxt;

  rgbhsv_pkg::ctl_t ctl_b_r;
  logic [TW-1:0]    t_b_r;
  logic [W-1:0]     delta_b_r;
  logic [W-1:0]     mx_b_r;

  always_comb begin
    case (sel_a_r)
      SEL_RED:   kd = diff_a_r[W] ? TW'(delta_a_r) * TW'(6) : '0;
      SEL_GREEN: kd = TW'(delta_a_r) * TW'(2);
      SEL_BLUE:  kd = TW'(delta_a_r) * TW'(4);
      default:   kd = '0;
    endcase
    t_nxt = {{2{diff_a_r[W]}}, diff_a_r} + kd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else begin
      ctl_b_r <= '{valid: valid_a_r, gray: gray_a_r};
    end
    t_b_r     <= t_nxt;
    delta_b_r <= delta_a_r;
    mx_b_r    <= mx_a_r;
  end

  // ---------------- scale numerators into the dividers ----------------
  logic [NW-1:0] hue_num;
  logic [NW-1:0] sat_num;

  assign hue_num = NW'(t_b_r) * NW'(rgbhsv_pkg::HUE_UNITS_SEXTANT);
  // full-scale code times delta: delta * 2^W - delta
  assign sat_num = (NW'(delta_b_r) << W) - NW'(delta_b_r);

  rgbhsv_pkg::ctl_t     ctl_d;
  logic [DIV_STEPS-1:0] hue_q;
  logic [DIV_STEPS-1:0] sat_q;
  logic [W-1:0]         val_d;

  rgbhsv_div_pipe #(
    .COMP_W (W),
    .STEPS  (DIV_STEPS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_b_r),
    .hue_num_i (hue_num),
    .hue_den_i (delta_b_r),
    .sat_num_i (sat_num),
    .sat_den_i (mx_b_r),
    .ctl_o     (ctl_d),
    .hue_q_o   (hue_q),
    .sat_q_o   (sat_q),
    .val_o     (val_d)
  );

  // ---------------- output register: zero hue and saturation on gray ----------------
  logic                         out_valid_r;
  logic [rgbhsv_pkg::HUE_W-1:0] out_hue_r;
  logic [W-1:0]                 out_sat_r;
  logic [W-1:0]                 out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_d.valid;
    end
    out_hue_r <= ctl_d.gray ? '0 : hue_q[rgbhsv_pkg::HUE_W-1:0];
    out_sat_r <= ctl_d.gray ? '0 : sat_q[W-1:0];
    out_val_r <= val_d;
  end

  assign out_valid   = out_valid_r;
  assign out_hue_out = out_hue_r;
  assign out_sat_out = out_sat_r;
  assign out_val_out = out_val_r;

  `RGBHSV_ASSERT(a_result_origin, clk, rst_n, out_valid |-> $past(start, LATENCY))
  `RGBHSV_ASSERT(a_black_all_zero, clk, rst_n, out_valid && (out_val_out == '0) |-> (out_hue_out == '0) && (out_sat_out == '0))
  `RGBHSV_ASSERT(a_hue_in_range, clk, rst_n, out_valid |-> out_hue_out < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_UNITS_TURN))
  `RGBHSV_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule
